// ----- design/nmea_rmc_position_parser_top_macros.svh -----
// assertion macros shared by the parser design files
// each macro expects clk and rst_n in the scope where it is used
`ifndef NMEA_RMC_POSITION_PARSER_TOP_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/nrp_pkg.sv -----
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and constants of the RMC sentence position parser: character
// codes, field numbers, status codes, saturation limits and the record types
// passed between the parser, the result builder and the output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrp_pkg;

  // result status codes
  localparam logic [1:0] ST_BAD   = 2'd0;
  localparam logic [1:0] ST_NOFIX = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_OK    = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // header and comma bookkeeping
  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [3:0] COMMA_MAX  = 4'd15;
  localparam logic [3:0] COMMA_NEED = 4'd8;

  // field numbers (text after comma n)
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_FIX  = 4'd2;
  localparam logic [3:0] FLD_LAT  = 4'd3;
  localparam logic [3:0] FLD_NS   = 4'd4;
  localparam logic [3:0] FLD_LON  = 4'd5;
  localparam logic [3:0] FLD_EW   = 4'd6;

  // whole part kept as hundreds plus two bcd digits; saturation values
  localparam logic [7:0]  LAT_HI_MAX   = 8'd163;
  localparam logic [6:0]  LAT_LO_MAX   = 7'd83;
  localparam logic [3:0]  LAT_TENS_SAT = 4'd8;
  localparam logic [3:0]  LAT_ONES_SAT = 4'd3;
  localparam logic [10:0] LON_HI_MAX   = 11'd1310;
  localparam logic [6:0]  LON_LO_MAX   = 7'd71;
  localparam logic [3:0]  LON_TENS_SAT = 4'd7;
  localparam logic [3:0]  LON_ONES_SAT = 4'd1;

  // range limits in whole minutes of arc
  localparam logic [13:0] LAT_LIMIT_MIN = 14'd5400;
  localparam logic [16:0] LON_LIMIT_MIN = 17'd10800;
  localparam logic [6:0]  MIN_PER_DEG   = 7'd60;

  // parse state seen by the result builder
  typedef struct packed {
    logic        good;
    logic        fix;
    logic [23:0] utc;
    logic [7:0]  lat_hi;
    logic [3:0]  lat_tens;
    logic [3:0]  lat_ones;
    logic [10:0] lon_hi;
    logic [3:0]  lon_tens;
    logic [3:0]  lon_ones;
    logic        south;
    logic        west;
  } snap_t;

  // one result record
  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] utc_bcd;
    logic [6:0]  lat_degrees;
    logic [5:0]  lat_minutes;
    logic [5:0]  lat_seconds;
    logic        lat_south;
    logic [7:0]  lon_degrees;
    logic [5:0]  lon_minutes;
    logic [5:0]  lon_seconds;
    logic        lon_west;
  } res_t;

  // place value of a fraction digit
  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] v;
    case (n)
      3'd0:    v = 20'd1;
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/nmea_rmc_position_parser_top.sv -----
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser_top
// RMC sentence position parser, one sentence byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one byte every clock cycle while in_ready is high. Each byte
// updates the parse state; on the byte flagged as sentence end, the result
// record (status, utc time, latitude and longitude in degrees, minutes and
// whole seconds) is written into a two-entry output queue and appears on the
// result channel the cycle after that byte is accepted when the queue was
// empty, otherwise once the older result has been taken. Input ready
// drops only when both queue entries hold results not yet taken. Seconds
// come from a registered reciprocal multiply of each fraction, one per axis;
// there is no clearing pass after reset.
`timescale 1ns / 1ps

module nmea_rmc_position_parser_top #(
  parameter int FIELD_LIMIT = 15,
  parameter int FRAC_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_sentence_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [23:0] out_utc_bcd,
  output logic [6:0]  out_lat_degrees,
  output logic [5:0]  out_lat_minutes,
  output logic [5:0]  out_lat_seconds,
  output logic        out_lat_south,
  output logic [7:0]  out_lon_degrees,
  output logic [5:0]  out_lon_minutes,
  output logic [5:0]  out_lon_seconds,
  output logic        out_lon_west
);
  import nrp_pkg::*;

  localparam int FRAC_W = $clog2(10**FRAC_DIGITS);

  logic              take;
  snap_t             snap;
  logic [FRAC_W-1:0] lat_frac;
  logic [FRAC_W-1:0] lon_frac;
  logic [5:0]        lat_sec;
  logic [5:0]        lon_sec;
  res_t              new_res;
  res_t              head_res;
  logic              not_full;

  assign in_ready = not_full;
  assign take     = in_valid && in_ready;

  // byte parser
  nrp_parser #(
    .FIELD_LIMIT(FIELD_LIMIT),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_in     (in_char_in),
    .sentence_end(in_sentence_end),
    .snap        (snap),
    .lat_frac    (lat_frac),
    .lon_frac    (lon_frac)
  );

  // fraction of a minute to seconds, per axis
  nrp_frac_sec #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_lat_sec (
    .clk    (clk),
    .frac   (lat_frac),
    .seconds(lat_sec)
  );

  nrp_frac_sec #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_lon_sec (
    .clk    (clk),
    .frac   (lon_frac),
    .seconds(lon_sec)
  );

  // result record
  nrp_compose #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_compose (
    .snap    (snap),
    .lat_frac(lat_frac),
    .lon_frac(lon_frac),
    .lat_sec (lat_sec),
    .lon_sec (lon_sec),
    .res     (new_res)
  );

  // result queue
  nrp_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take && in_sentence_end),
    .push_res (new_res),
    .not_full (not_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (head_res)
  );

  // result ports
  assign out_status      = head_res.status;
  assign out_utc_bcd     = head_res.utc_bcd;
  assign out_lat_degrees = head_res.lat_degrees;
  assign out_lat_minutes = head_res.lat_minutes;
  assign out_lat_seconds = head_res.lat_seconds;
  assign out_lat_south   = head_res.lat_south;
  assign out_lon_degrees = head_res.lon_degrees;
  assign out_lon_minutes = head_res.lon_minutes;
  assign out_lon_seconds = head_res.lon_seconds;
  assign out_lon_west    = head_res.lon_west;

endmodule

// ----- design/nrp_parser.sv -----
// ----------------------------------------------------------------------------
// nrp_parser
// Per-byte sentence state: header match, comma count, field character count,
// time digits, fix flag, latitude and longitude accumulators, hemispheres.
// Returns to its reset state after the byte that ends a sentence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_rmc_position_parser_top_macros.svh"

module nrp_parser #(
  parameter int FIELD_LIMIT = 15,
  parameter int FRAC_DIGITS = 4
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    take,
  input  logic [7:0]                              char_in,
  input  logic                                    sentence_end,
  output nrp_pkg::snap_t                          snap,
  output logic [$clog2(10**FRAC_DIGITS)-1:0]      lat_frac,
  output logic [$clog2(10**FRAC_DIGITS)-1:0]      lon_frac
);
  import nrp_pkg::*;

  localparam int FC_W   = $clog2(FIELD_LIMIT + 1);
  localparam int FRAC_W = $clog2(10**FRAC_DIGITS);
  localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);

  logic [2:0]        header_pos_r, header_pos_nxt;
  logic              header_ok_r, header_ok_nxt;
  logic [3:0]        comma_count_r, comma_count_nxt;
  logic [FC_W-1:0]   field_chars_r, field_chars_nxt;
  logic [23:0]       time_digits_r, time_digits_nxt;
  logic              fix_flag_r, fix_flag_nxt;
  logic [7:0]        lat_hi_r, lat_hi_nxt;
  logic [3:0]        lat_tens_r, lat_tens_nxt;
  logic [3:0]        lat_ones_r, lat_ones_nxt;
  logic [FRAC_W-1:0] lat_frac_r, lat_frac_nxt;
  logic [10:0]       lon_hi_r, lon_hi_nxt;
  logic [3:0]        lon_tens_r, lon_tens_nxt;
  logic [3:0]        lon_ones_r, lon_ones_nxt;
  logic [FRAC_W-1:0] lon_frac_r, lon_frac_nxt;
  logic              in_fraction_r, in_fraction_nxt;
  logic              num_stop_r, num_stop_nxt;
  logic [FCNT_W-1:0] frac_cnt_r, frac_cnt_nxt;
  logic [1:0]        hemisphere_r, hemisphere_nxt;

  // character decode
  logic              is_digit;
  logic [3:0]        digit;
  logic              hdr_char_ok;
  logic [FRAC_W-1:0] frac_add;

  // sentence check including this byte, taken before the end-of-sentence clear
  logic              sent_good;

  // whole-part candidates with saturation
  logic [10:0] lat_hi_cand;
  logic [13:0] lon_hi_cand;
  logic [6:0]  lat_lo_cand;
  logic [6:0]  lon_lo_cand;
  logic        lat_sat;
  logic        lon_sat;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign digit    = char_in[3:0];
  assign frac_add = FRAC_W'(digit) *
                    FRAC_W'(pow10(3'(FRAC_DIGITS - 1) - 3'(frac_cnt_r)));

  assign lat_hi_cand = 11'(lat_hi_r) * 11'd10 + 11'(lat_tens_r);
  assign lat_lo_cand = 7'(lat_ones_r) * 7'd10 + 7'(digit);
  assign lat_sat     = (lat_hi_cand > 11'(LAT_HI_MAX)) ||
                       ((lat_hi_cand == 11'(LAT_HI_MAX)) && (lat_lo_cand > LAT_LO_MAX));
  assign lon_hi_cand = 14'(lon_hi_r) * 14'd10 + 14'(lon_tens_r);
  assign lon_lo_cand = 7'(lon_ones_r) * 7'd10 + 7'(digit);
  assign lon_sat     = (lon_hi_cand > 14'(LON_HI_MAX)) ||
                       ((lon_hi_cand == 14'(LON_HI_MAX)) && (lon_lo_cand > LON_LO_MAX));

  // header character check by position
  always_comb begin
    case (header_pos_r)
      3'd0:    hdr_char_ok = (char_in == CH_DOLLAR);
      3'd1:    hdr_char_ok = (char_in == CH_G);
      3'd2:    hdr_char_ok = (char_in == CH_N) || (char_in == CH_P);
      3'd3:    hdr_char_ok = (char_in == CH_R);
      3'd4:    hdr_char_ok = (char_in == CH_M);
      default: hdr_char_ok = (char_in == CH_C);
    endcase
  end

  // next state for one byte
  always_comb begin
    header_pos_nxt  = header_pos_r;
    header_ok_nxt   = header_ok_r;
    comma_count_nxt = comma_count_r;
    field_chars_nxt = field_chars_r;
    time_digits_nxt = time_digits_r;
    fix_flag_nxt    = fix_flag_r;
    lat_hi_nxt      = lat_hi_r;
    lat_tens_nxt    = lat_tens_r;
    lat_ones_nxt    = lat_ones_r;
    lat_frac_nxt    = lat_frac_r;
    lon_hi_nxt      = lon_hi_r;
    lon_tens_nxt    = lon_tens_r;
    lon_ones_nxt    = lon_ones_r;
    lon_frac_nxt    = lon_frac_r;
    in_fraction_nxt = in_fraction_r;
    num_stop_nxt    = num_stop_r;
    frac_cnt_nxt    = frac_cnt_r;
    hemisphere_nxt  = hemisphere_r;
    sent_good       = 1'b0;

    if (take) begin
      // header match
      if (header_pos_r < HDR_LEN) begin
        if (!hdr_char_ok) begin
          header_ok_nxt = 1'b0;
        end
        header_pos_nxt = header_pos_r + 3'd1;
      end

      if (char_in == CH_COMMA) begin
        // field boundary
        if (comma_count_r < COMMA_MAX) begin
          comma_count_nxt = comma_count_r + 4'd1;
        end
        field_chars_nxt = '0;
        in_fraction_nxt = 1'b0;
        num_stop_nxt    = 1'b0;
        frac_cnt_nxt    = '0;
      end else if (field_chars_r < FC_W'(FIELD_LIMIT)) begin
        case (comma_count_r)
          FLD_TIME: begin
            for (int i = 0; i < 6; i++) begin
              if (field_chars_r == FC_W'(5 - i)) begin
                time_digits_nxt[4*i +: 4] = time_digits_r[4*i +: 4] | digit;
              end
            end
          end
          FLD_FIX: begin
            if (field_chars_r == '0) begin
              fix_flag_nxt = (char_in == CH_A);
            end
          end
          FLD_LAT, FLD_LON: begin
            if (!num_stop_r) begin
              if (is_digit && !in_fraction_r) begin
                // whole part, saturating
                if (comma_count_r == FLD_LAT) begin
                  if (lat_sat) begin
                    lat_hi_nxt   = LAT_HI_MAX;
                    lat_tens_nxt = LAT_TENS_SAT;
                    lat_ones_nxt = LAT_ONES_SAT;
                  end else begin
                    lat_hi_nxt   = lat_hi_cand[7:0];
                    lat_tens_nxt = lat_ones_r;
                    lat_ones_nxt = digit;
                  end
                end else begin
                  if (lon_sat) begin
                    lon_hi_nxt   = LON_HI_MAX;
                    lon_tens_nxt = LON_TENS_SAT;
                    lon_ones_nxt = LON_ONES_SAT;
                  end else begin
                    lon_hi_nxt   = lon_hi_cand[10:0];
                    lon_tens_nxt = lon_ones_r;
                    lon_ones_nxt = digit;
                  end
                end
              end else if (is_digit) begin
                // fraction digit, extra digits dropped
                if (frac_cnt_r < FCNT_W'(FRAC_DIGITS)) begin
                  if (comma_count_r == FLD_LAT) begin
                    lat_frac_nxt = lat_frac_r + frac_add;
                  end else begin
                    lon_frac_nxt = lon_frac_r + frac_add;
                  end
                  frac_cnt_nxt = frac_cnt_r + FCNT_W'(1);
                end
              end else if ((char_in == CH_DOT) && !in_fraction_r) begin
                in_fraction_nxt = 1'b1;
              end else begin
                num_stop_nxt = 1'b1;
              end
            end
          end
          FLD_NS: begin
            if ((field_chars_r == '0) && (char_in == CH_S)) begin
              hemisphere_nxt[0] = 1'b1;
            end
          end
          FLD_EW: begin
            if ((field_chars_r == '0) && (char_in == CH_W)) begin
              hemisphere_nxt[1] = 1'b1;
            end
          end
          default: begin
          end
        endcase
        field_chars_nxt = field_chars_r + FC_W'(1);
      end

      // header and comma check with this byte counted
      sent_good = header_ok_nxt && (header_pos_nxt >= HDR_LEN) &&
                  (comma_count_nxt >= COMMA_NEED);

      // sentence done: back to reset state
      if (sentence_end) begin
        header_pos_nxt  = '0;
        header_ok_nxt   = 1'b1;
        comma_count_nxt = '0;
        field_chars_nxt = '0;
        time_digits_nxt = '0;
        fix_flag_nxt    = 1'b0;
        lat_hi_nxt      = '0;
        lat_tens_nxt    = '0;
        lat_ones_nxt    = '0;
        lat_frac_nxt    = '0;
        lon_hi_nxt      = '0;
        lon_tens_nxt    = '0;
        lon_ones_nxt    = '0;
        lon_frac_nxt    = '0;
        in_fraction_nxt = 1'b0;
        num_stop_nxt    = 1'b0;
        frac_cnt_nxt    = '0;
        hemisphere_nxt  = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pos_r  <= '0;
      header_ok_r   <= 1'b1;
      comma_count_r <= '0;
      field_chars_r <= '0;
      time_digits_r <= '0;
      fix_flag_r    <= 1'b0;
      lat_hi_r      <= '0;
      lat_tens_r    <= '0;
      lat_ones_r    <= '0;
      lat_frac_r    <= '0;
      lon_hi_r      <= '0;
      lon_tens_r    <= '0;
      lon_ones_r    <= '0;
      lon_frac_r    <= '0;
      in_fraction_r <= 1'b0;
      num_stop_r    <= 1'b0;
      frac_cnt_r    <= '0;
      hemisphere_r  <= '0;
    end else begin
      header_pos_r  <= header_pos_nxt;
      header_ok_r   <= header_ok_nxt;
      comma_count_r <= comma_count_nxt;
      field_chars_r <= field_chars_nxt;
      time_digits_r <= time_digits_nxt;
      fix_flag_r    <= fix_flag_nxt;
      lat_hi_r      <= lat_hi_nxt;
      lat_tens_r    <= lat_tens_nxt;
      lat_ones_r    <= lat_ones_nxt;
      lat_frac_r    <= lat_frac_nxt;
      lon_hi_r      <= lon_hi_nxt;
      lon_tens_r    <= lon_tens_nxt;
      lon_ones_r    <= lon_ones_nxt;
      lon_frac_r    <= lon_frac_nxt;
      in_fraction_r <= in_fraction_nxt;
      num_stop_r    <= num_stop_nxt;
      frac_cnt_r    <= frac_cnt_nxt;
      hemisphere_r  <= hemisphere_nxt;
    end
  end

  // state for the result builder; sentence check uses this byte's update
  always_comb begin
    snap.good     = sent_good;
    snap.fix      = fix_flag_r;
    snap.utc      = time_digits_r;
    snap.lat_hi   = lat_hi_r;
    snap.lat_tens = lat_tens_r;
    snap.lat_ones = lat_ones_r;
    snap.lon_hi   = lon_hi_r;
    snap.lon_tens = lon_tens_r;
    snap.lon_ones = lon_ones_r;
    snap.south    = hemisphere_r[0];
    snap.west     = hemisphere_r[1];
  end

  assign lat_frac = lat_frac_r;
  assign lon_frac = lon_frac_r;

  `NRP_ASSERT_NEXT(a_end_clears, take && sentence_end, (comma_count_r == 4'd0) && (header_pos_r == 3'd0) && header_ok_r, "parse state not cleared after sentence end")

endmodule

// ----- design/nrp_frac_sec.sv -----
// ----------------------------------------------------------------------------
// nrp_frac_sec
// Converts a decimal fraction of a minute into whole seconds, truncated,
// by multiplying with a scaled reciprocal. Output is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrp_frac_sec #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic                               clk,
  input  logic [$clog2(10**FRAC_DIGITS)-1:0] frac,
  output logic [5:0]                         seconds
);

  localparam int unsigned     FSCALE  = 10**FRAC_DIGITS;
  localparam int              FRAC_W  = $clog2(FSCALE);
  localparam longint unsigned FSQ     = 64'(FSCALE) * 64'(FSCALE);
  localparam int              SHIFT   = $clog2(FSQ);
  // ceil(60 * 2^SHIFT / FSCALE); exact floor for every fraction below FSCALE
  localparam longint unsigned RECIP   = ((64'd60 << SHIFT) + 64'(FSCALE) - 64'd1) /
                                        64'(FSCALE);
  localparam int              RECIP_W = $clog2(RECIP + 1);
  localparam int              PROD_W  = SHIFT + 7;

  logic [PROD_W-1:0] prod;
  logic [5:0]        sec_r;

  // frac * 60 / FSCALE
  assign prod = PROD_W'(frac) * PROD_W'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    sec_r <= prod[SHIFT +: 6];
  end

  assign seconds = sec_r;

endmodule

// ----- design/nrp_compose.sv -----
// ----------------------------------------------------------------------------
// nrp_compose
// Builds the result record from the parse state: range check in whole
// minutes plus fraction, carry of minutes into degrees, status selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrp_compose #(
  parameter int FRAC_DIGITS = 4
) (
  input  nrp_pkg::snap_t                     snap,
  input  logic [$clog2(10**FRAC_DIGITS)-1:0] lat_frac,
  input  logic [$clog2(10**FRAC_DIGITS)-1:0] lon_frac,
  input  logic [5:0]                         lat_sec,
  input  logic [5:0]                         lon_sec,
  output nrp_pkg::res_t                      res
);
  import nrp_pkg::*;

  logic [6:0]  lat_mins;
  logic [6:0]  lon_mins;
  logic [13:0] lat_total;
  logic [16:0] lon_total;
  logic        lat_over;
  logic        lon_over;
  logic        lat_carry;
  logic        lon_carry;

  // minutes from the two low digits, total minutes of arc
  assign lat_mins  = 7'(snap.lat_tens) * 7'd10 + 7'(snap.lat_ones);
  assign lon_mins  = 7'(snap.lon_tens) * 7'd10 + 7'(snap.lon_ones);
  assign lat_total = 14'(snap.lat_hi) * 14'(MIN_PER_DEG) + 14'(lat_mins);
  assign lon_total = 17'(snap.lon_hi) * 17'(MIN_PER_DEG) + 17'(lon_mins);

  // above 90 or 180 degrees, fraction counted
  assign lat_over = (lat_total > LAT_LIMIT_MIN) ||
                    ((lat_total == LAT_LIMIT_MIN) && (lat_frac != '0));
  assign lon_over = (lon_total > LON_LIMIT_MIN) ||
                    ((lon_total == LON_LIMIT_MIN) && (lon_frac != '0));

  // minutes of 60 to 99 carry one degree
  assign lat_carry = (lat_mins >= MIN_PER_DEG);
  assign lon_carry = (lon_mins >= MIN_PER_DEG);

  always_comb begin
    res = '0;
    if (snap.good) begin
      res.utc_bcd = snap.utc;
      if (!snap.fix) begin
        res.status = ST_NOFIX;
      end else if (lat_over || lon_over) begin
        res.status = ST_RANGE;
      end else begin
        res.status      = ST_OK;
        res.lat_degrees = snap.lat_hi[6:0] + 7'(lat_carry);
        res.lat_minutes = lat_carry ? 6'(lat_mins - MIN_PER_DEG) : lat_mins[5:0];
        res.lat_seconds = lat_sec;
        res.lat_south   = snap.south;
        res.lon_degrees = snap.lon_hi[7:0] + 8'(lon_carry);
        res.lon_minutes = lon_carry ? 6'(lon_mins - MIN_PER_DEG) : lon_mins[5:0];
        res.lon_seconds = lon_sec;
        res.lon_west    = snap.west;
      end
    end else begin
      res.status = ST_BAD;
    end
  end

endmodule

// ----- design/nrp_out_queue.sv -----
// ----------------------------------------------------------------------------
// nrp_out_queue
// Two-entry result queue: the head drives the result channel, the second
// entry lets the parser keep taking bytes while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_rmc_position_parser_top_macros.svh"

module nrp_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nrp_pkg::res_t push_res,
  output logic          not_full,
  output logic          out_valid,
  input  logic          out_ready,
  output nrp_pkg::res_t out_res
);
  import nrp_pkg::*;

  logic [1:0] count_r, count_nxt;
  res_t       head_r, head_nxt;
  res_t       tail_r, tail_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign not_full  = (count_r != 2'd2);
  assign out_res   = head_r;

  // queue update
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_res;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_res;
        end else if (push) begin
          tail_nxt  = push_res;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  `NRP_ASSERT_NEXT(a_shift_up, pop && (count_r == 2'd2), out_valid && (head_r == $past(tail_r)), "second entry not moved to head")
  `NRP_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 2'd1, "push did not grow the queue")
  `NRP_ASSERT_SAME(a_ok_fields, out_valid && (head_r.status == ST_OK), (head_r.lat_minutes < 6'd60) && (head_r.lon_minutes < 6'd60) && (head_r.lat_seconds < 6'd60) && (head_r.lon_seconds < 6'd60), "ok result with minutes or seconds out of range")

endmodule

// ----- tb/nmea_rmc_position_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_rmc_position_checker
// Watches both channels of the RMC position parser, tracks the sentence
// parse byte by byte, queues the result expected at each sentence end and
// compares every result transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_rmc_position_checker #(
  parameter int FIELD_LIMIT = 15,
  parameter int FRAC_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_sentence_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [23:0] out_utc_bcd,
  input  logic [6:0]  out_lat_degrees,
  input  logic [5:0]  out_lat_minutes,
  input  logic [5:0]  out_lat_seconds,
  input  logic        out_lat_south,
  input  logic [7:0]  out_lon_degrees,
  input  logic [5:0]  out_lon_minutes,
  input  logic [5:0]  out_lon_seconds,
  input  logic        out_lon_west,
  output int          fail_count,
  output int          pending_count
);
  import nrp_pkg::*;

  function automatic longint unsigned decimal_scale(input int n);
    longint unsigned v;
    v = 1;
    for (int i = 0; i < n; i++) v = v * 10;
    return v;
  endfunction

  localparam longint unsigned FRAC_SCALE = decimal_scale(FRAC_DIGITS);
  localparam int unsigned     LAT_SAT    = 16383;
  localparam int unsigned     LON_SAT    = 131071;

  // running parse of the current sentence
  logic [2:0]  hdr_idx;
  logic        hdr_good;
  logic [3:0]  commas;
  int          fchars;
  logic [23:0] utc_acc;
  logic        fix_seen;
  int unsigned lat_int;
  int unsigned lat_frac;
  int unsigned lon_int;
  int unsigned lon_frac;
  logic        frac_mode;
  logic [1:0]  hemi;
  logic        num_halt;
  int unsigned frac_weight;

  res_t sentence_results_q[$];
  res_t predicted;
  res_t wanted;

  function automatic void clear_parse();
    hdr_idx     = '0;
    hdr_good    = 1'b1;
    commas      = '0;
    fchars      = 0;
    utc_acc     = '0;
    fix_seen    = 1'b0;
    lat_int     = 0;
    lat_frac    = 0;
    lon_int     = 0;
    lon_frac    = 0;
    frac_mode   = 1'b0;
    hemi        = '0;
    num_halt    = 1'b0;
    frac_weight = 0;
  endfunction

  // digit, point or terminator of a latitude / longitude field
  function automatic void number_digit(input logic [7:0] c, inout int unsigned whole,
                                       input int unsigned cap, inout int unsigned frac);
    int unsigned w;
    if (num_halt) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!frac_mode) begin
        w = whole * 10 + (c - CH_ZERO);
        whole = (w > cap) ? cap : w;
      end else if (frac_weight != 0) begin
        frac = frac + (c - CH_ZERO) * frac_weight;
        frac_weight = frac_weight / 10;
      end
    end else if (c == CH_DOT && !frac_mode) begin
      frac_mode   = 1'b1;
      frac_weight = int'(FRAC_SCALE / 10);
    end else begin
      num_halt = 1'b1;
    end
  endfunction

  // angle in units of one minute / FRAC_SCALE
  function automatic longint unsigned arc_units(input int unsigned whole,
                                                input int unsigned frac);
    longint unsigned w;
    w = whole;
    return (w / 100) * 60 * FRAC_SCALE + (w % 100) * FRAC_SCALE + frac;
  endfunction

  function automatic void to_deg_min_sec(input longint unsigned t, output int unsigned d,
                                         output int unsigned m, output int unsigned s);
    longint unsigned rem;
    rem = t % (60 * FRAC_SCALE);
    d = int'(t / (60 * FRAC_SCALE));
    m = int'(rem / FRAC_SCALE);
    s = int'(((rem % FRAC_SCALE) * 60) / FRAC_SCALE);
  endfunction

  // advance the parse by one byte; returns 1 with the result on a sentence end
  function automatic bit parse_byte(input logic [7:0] c, input logic last,
                                    output res_t r);
    logic            ok;
    longint unsigned lat_u;
    longint unsigned lon_u;
    int unsigned     d, m, s;
    r = '0;
    if (hdr_idx < HDR_LEN) begin
      case (hdr_idx)
        3'd0:    ok = (c == CH_DOLLAR);
        3'd1:    ok = (c == CH_G);
        3'd2:    ok = (c == CH_N) || (c == CH_P);
        3'd3:    ok = (c == CH_R);
        3'd4:    ok = (c == CH_M);
        default: ok = (c == CH_C);
      endcase
      if (!ok) hdr_good = 1'b0;
      hdr_idx = hdr_idx + 3'd1;
    end

    if (c == CH_COMMA) begin
      if (commas < COMMA_MAX) commas = commas + 4'd1;
      fchars      = 0;
      frac_mode   = 1'b0;
      num_halt    = 1'b0;
      frac_weight = 0;
    end else if (fchars < FIELD_LIMIT) begin
      case (commas)
        FLD_TIME: if (fchars < 6) utc_acc = utc_acc | (24'(c[3:0]) << (4 * (5 - fchars)));
        FLD_FIX:  if (fchars == 0) fix_seen = (c == CH_A);
        FLD_LAT:  number_digit(c, lat_int, LAT_SAT, lat_frac);
        FLD_NS:   if (fchars == 0 && c == CH_S) hemi[0] = 1'b1;
        FLD_LON:  number_digit(c, lon_int, LON_SAT, lon_frac);
        FLD_EW:   if (fchars == 0 && c == CH_W) hemi[1] = 1'b1;
        default: ;
      endcase
      fchars++;
    end

    if (!last) return 1'b0;

    if (hdr_good && hdr_idx >= HDR_LEN && commas >= COMMA_NEED) begin
      r.utc_bcd = utc_acc;
      if (!fix_seen) begin
        r.status = ST_NOFIX;
      end else begin
        lat_u = arc_units(lat_int, lat_frac);
        lon_u = arc_units(lon_int, lon_frac);
        if (lat_u > 90 * 60 * FRAC_SCALE || lon_u > 180 * 60 * FRAC_SCALE) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          to_deg_min_sec(lat_u, d, m, s);
          r.lat_degrees = 7'(d);
          r.lat_minutes = 6'(m);
          r.lat_seconds = 6'(s);
          r.lat_south   = hemi[0];
          to_deg_min_sec(lon_u, d, m, s);
          r.lon_degrees = 8'(d);
          r.lon_minutes = 6'(m);
          r.lon_seconds = 6'(s);
          r.lon_west    = hemi[1];
        end
      end
    end else begin
      r.status = ST_BAD;
    end
    clear_parse();
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  // track input bytes, then compare any result transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      sentence_results_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        if (parse_byte(in_char_in, in_sentence_end, predicted))
          sentence_results_q.push_back(predicted);
      if (out_valid && out_ready) begin
        if (sentence_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result transaction with no sentence end pending", $realtime);
        end else begin
          wanted = sentence_results_q.pop_front();
          check_field("status",      wanted.status,      out_status);
          check_field("utc_bcd",     wanted.utc_bcd,     out_utc_bcd);
          check_field("lat_degrees", wanted.lat_degrees, out_lat_degrees);
          check_field("lat_minutes", wanted.lat_minutes, out_lat_minutes);
          check_field("lat_seconds", wanted.lat_seconds, out_lat_seconds);
          check_field("lat_south",   wanted.lat_south,   out_lat_south);
          check_field("lon_degrees", wanted.lon_degrees, out_lon_degrees);
          check_field("lon_minutes", wanted.lon_minutes, out_lon_minutes);
          check_field("lon_seconds", wanted.lon_seconds, out_lon_seconds);
          check_field("lon_west",    wanted.lon_west,    out_lon_west);
        end
      end
    end
    pending_count = sentence_results_q.size();
  end

endmodule

// ----- tb/tb_nmea_rmc_position_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_nmea_rmc_position_parser_top
// Feeds the RMC position parser with corner-case sentences, then a mix
// of randomized RMC sentences, broken sentences and byte noise, with random
// gaps and stalls on both channels; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nmea_rmc_position_parser_top;
  import nrp_pkg::*;

  localparam int FIELD_LIMIT = 15;
  localparam int FRAC_DIGITS = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        in_sentence_end;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [23:0] out_utc_bcd;
  logic [6:0]  out_lat_degrees;
  logic [5:0]  out_lat_minutes;
  logic [5:0]  out_lat_seconds;
  logic        out_lat_south;
  logic [7:0]  out_lon_degrees;
  logic [5:0]  out_lon_minutes;
  logic [5:0]  out_lon_seconds;
  logic        out_lon_west;

  int fails;
  int pending;

  logic [7:0] line_buf[$];
  int         bytes_sent;
  int         rand_lines;
  bit         tx_gaps;

  nmea_rmc_position_parser_top #(
    .FIELD_LIMIT(FIELD_LIMIT),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_in(in_char_in), .in_sentence_end(in_sentence_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_utc_bcd(out_utc_bcd),
    .out_lat_degrees(out_lat_degrees), .out_lat_minutes(out_lat_minutes),
    .out_lat_seconds(out_lat_seconds), .out_lat_south(out_lat_south),
    .out_lon_degrees(out_lon_degrees), .out_lon_minutes(out_lon_minutes),
    .out_lon_seconds(out_lon_seconds), .out_lon_west(out_lon_west)
  );

  nmea_rmc_position_checker #(
    .FIELD_LIMIT(FIELD_LIMIT),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_in(in_char_in), .in_sentence_end(in_sentence_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_utc_bcd(out_utc_bcd),
    .out_lat_degrees(out_lat_degrees), .out_lat_minutes(out_lat_minutes),
    .out_lat_seconds(out_lat_seconds), .out_lat_south(out_lat_south),
    .out_lon_degrees(out_lon_degrees), .out_lon_minutes(out_lon_minutes),
    .out_lon_seconds(out_lon_seconds), .out_lon_west(out_lon_west),
    .fail_count(fails), .pending_count(pending)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop for a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off, a stretch always ready, then random stalls again
  initial begin
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    repeat (300) begin
      out_ready <= ($urandom_range(0, 99) >= 20);
      @(negedge clk);
    end
    out_ready <= 1'b0;
    repeat (600) @(negedge clk);
    out_ready <= 1'b1;
    repeat (500) @(negedge clk);
    forever begin
      out_ready <= ($urandom_range(0, 99) >= 20);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] any_but_comma();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int unsigned v, input int n);
    int unsigned p;
    p = 1;
    repeat (n - 1) p = p * 10;
    repeat (n) begin
      line_buf.push_back(CH_ZERO + 8'((v / p) % 10));
      p = p / 10;
    end
  endtask

  task automatic add_random_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_junk(input int n);
    repeat (n) line_buf.push_back(any_but_comma());
  endtask

  // latitude or longitude text, mostly well formed
  task automatic add_coord(input int unsigned max_deg, input int dw);
    int          roll;
    int unsigned deg;
    int unsigned mins;
    int          n;
    int          dot_at;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      deg  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, max_deg)
                                          : $urandom_range(max_deg, (dw == 2) ? 99 : 999);
      mins = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(60, 99);
      add_digits(deg, dw);
      add_digits(mins, 2);
      if ($urandom_range(0, 99) < 80) begin
        line_buf.push_back(CH_DOT);
        add_random_digits($urandom_range(0, 6));
      end
    end else if (roll < 80) begin
      // right at the range limit, fraction mostly zero
      add_digits(max_deg, dw);
      add_text("00.");
      repeat ($urandom_range(0, 6))
        line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_ZERO + 8'($urandom_range(1, 9))
                                                       : CH_ZERO);
    end else if (roll < 86) begin
      // empty field
    end else if (roll < 93) begin
      n = $urandom_range(8, 20);
      dot_at = $urandom_range(0, n + 3);
      for (int i = 0; i < n; i++) begin
        if (i == dot_at) line_buf.push_back(CH_DOT);
        add_random_digits(1);
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       add_text("-");
          1:       add_text(".");
          2:       add_random_digits(1);
          default: add_junk(1);
        endcase
      end
    end
  endtask

  task automatic add_hemi(input string plain, input string flip);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      add_text(plain);
    else if (roll < 80) add_text(flip);
    else if (roll >= 90) add_junk($urandom_range(1, 2));
  endtask

  // one rmc sentence with random content, sometimes damaged
  task automatic make_rmc();
    logic [7:0] hdr[6];
    int         roll;
    int         n;
    hdr = '{CH_DOLLAR, CH_G, ($urandom_range(0, 1) ? CH_N : CH_P), CH_R, CH_M, CH_C};
    if ($urandom_range(0, 99) < 10) hdr[$urandom_range(0, 5)] = any_but_comma();
    foreach (hdr[i]) line_buf.push_back(hdr[i]);

    line_buf.push_back(CH_COMMA);
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      add_random_digits(6);
      if ($urandom_range(0, 1)) add_text(".00");
    end else if (roll < 85) begin
      add_random_digits($urandom_range(0, 5));
    end else begin
      add_junk($urandom_range(1, 8));
    end

    line_buf.push_back(CH_COMMA);
    roll = $urandom_range(0, 99);
    if (roll < 75)      line_buf.push_back(CH_A);
    else if (roll < 85) add_text("V");
    else if (roll >= 92) add_junk($urandom_range(1, 3));

    line_buf.push_back(CH_COMMA);
    add_coord(90, 2);
    line_buf.push_back(CH_COMMA);
    add_hemi("N", "S");
    line_buf.push_back(CH_COMMA);
    add_coord(180, 3);
    line_buf.push_back(CH_COMMA);
    add_hemi("E", "W");

    // trailing fields: usually enough commas, sometimes too few or far too many
    roll = $urandom_range(0, 99);
    if (roll < 70)      n = $urandom_range(2, 6);
    else if (roll < 85) n = $urandom_range(0, 1);
    else                n = $urandom_range(7, 12);
    repeat (n) begin
      line_buf.push_back(CH_COMMA);
      if ($urandom_range(0, 1)) add_random_digits($urandom_range(0, 6));
    end
    if ($urandom_range(0, 99) < 40) begin
      add_text("*");
      add_random_digits(2);
    end

    // cut the sentence short
    if ($urandom_range(0, 99) < 8 && line_buf.size() > 1) begin
      n = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
  endtask

  task automatic make_noise();
    if ($urandom_range(0, 99) < 30) add_text("$GPRMC");
    repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // one input transaction; starts and ends just after a falling edge
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (tx_gaps && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_char_in      <= c;
    in_sentence_end <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic emit_line();
    foreach (line_buf[i]) begin
      send_byte(line_buf[i], i == line_buf.size() - 1);
      bytes_sent++;
    end
    line_buf.delete();
  endtask

  task automatic send_line(input string s);
    add_text(s);
    emit_line();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_in      = '0;
    in_sentence_end = 1'b0;
    bytes_sent      = 0;
    rand_lines      = 0;
    tx_gaps         = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner cases
    send_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
    // both ranges exactly at their limit, south and west
    send_line("$GNRMC,235959.00,A,9000.0000,S,18000.0000,W,,,,");
    send_line("$GPRMC,000000,A,9000.0001,N,00000.0000,E,,");
    // fraction digit past the kept precision is dropped
    send_line("$GPRMC,010203,A,0000.0000,N,18000.00009,E,,");
    send_line("$GPRMC,010203,A,0000.0000,N,18000.0001,E,,");
    send_line("$GPRMC,111111,V,4807.038,N,01131.000,E,,");
    send_line("$GPRMC,111111,,4807.038,N,01131.000,E,,");
    // short header, wrong talker, one comma short, cut inside a number
    send_line("$GPR");
    send_line("$GLRMC,123519,A,4807.038,N,01131.000,E,,");
    send_line("$GPRMC,123519,A,4807.038,N,01131.000,E,");
    send_line("$GPRMC,123519,A,48");
    // short time, minutes over 59, lowercase hemisphere, sign, comma saturation
    send_line("$GPRMC,12,A,4575.5,s,-0113,XW,,,,,,,,,,,,,,");
    // letters in time, field longer than the scan limit, second point
    send_line("$GPRMC,A1:b?z9,A,0000000000000004807,N,12030.5.9,E,,");
    // whole part saturation on both axes
    send_line("$GPRMC,123456,A,99999999,S,999999999,W,,");
    // extra time digits, hemisphere letter followed by junk
    send_line("$GNRMC,12345678,A,0130.9999,SX,00059.99999,W,,");
    send_line("$");

    // random sentences and noise: first lines without gaps, then a full drain and the rest with gaps
    while (bytes_sent < 850 || rand_lines < 4) begin
      if (rand_lines == 0) tx_gaps = 1'b0;
      if (rand_lines == 2) begin
        tx_gaps = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 75) make_rmc();
      else                            make_noise();
      emit_line();
      rand_lines++;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- nmea_rmc_position_parser_top.f -----
+incdir+design
design/nrp_pkg.sv
design/nrp_parser.sv
design/nrp_frac_sec.sv
design/nrp_compose.sv
design/nrp_out_queue.sv
design/nmea_rmc_position_parser_top.sv
tb/nmea_rmc_position_checker.sv
tb/tb_nmea_rmc_position_parser_top.sv
